### design/slf_pkg.sv
// Shared constants and helpers for the substring line filter.
// No dependencies; imported by substring_line_filter.
package slf_pkg;

    // Default pattern capacity in bytes
    localparam int unsigned PATTERN_MAX_DEF = 64;

    // Item opcodes
    localparam logic OP_PATTERN = 1'b0;
    localparam logic OP_TEXT    = 1'b1;

    // Register map: index taken from paddr[2]
    localparam logic REG_CASE_SENSITIVE = 1'b0;
    localparam int unsigned APB_ADDR_W  = 3;
    localparam int unsigned APB_DATA_W  = 32;

    // ASCII bounds for case folding
    localparam logic [7:0] ASCII_UPPER_A = 8'h41;
    localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
    localparam logic [7:0] ASCII_LOWER_A = 8'h61;

    // Fold A-Z to a-z unless matching is case sensitive
    function automatic logic [7:0] slf_fold(input logic [7:0] c, input logic case_sens);
        logic [7:0] res;
        res = c;
        if (!case_sens && (c >= ASCII_UPPER_A) && (c <= ASCII_UPPER_Z)) begin
            res = c - ASCII_UPPER_A + ASCII_LOWER_A;
        end
        return res;
    endfunction

endpackage

### design/substring_line_filter.sv
// Substring line filter: top level, streams pattern and text bytes, reports per line.
// Depends on slf_pkg (constants, opcodes, case folding).
//
//  channel  | dir | ports                                   | moves
//  ---------+-----+-----------------------------------------+---------------------------
//  s_       | in  | s_valid s_ready s_op s_ch s_last        | one pattern or text byte
//  m_       | out | m_valid m_ready m_found m_pattern_clipped | one verdict per line end
//  apb      | in  | psel penable pwrite paddr pwdata prdata pready | case_sensitive @ 0x0
//
// One item is taken per cycle; a verdict shows in the cycle after its line's last byte.
// The window compare is combinational, across PATTERN_MAX byte lanes in parallel.
// A waiting verdict stalls input only if m_ready is low (s_ready = !m_valid | m_ready).
// aresetn is synchronous, active low; no clearing pass is needed after reset.
// Text window and pattern shift lines carry no reset: lanes beyond the line
// length or pattern length are masked off by the counters.
module substring_line_filter #(
    parameter int unsigned PATTERN_MAX = slf_pkg::PATTERN_MAX_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input items
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_op,
    input  logic [7:0]                      s_ch,
    input  logic                            s_last,
    // results
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_found,
    output logic                            m_pattern_clipped,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [slf_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [slf_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [slf_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import slf_pkg::*;

    localparam int unsigned LEN_W = $clog2(PATTERN_MAX + 1);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(PATTERN_MAX);

    // Pattern is held right-aligned: pat_reg[0] is the newest pattern byte,
    // so pat_reg[j] lines up with win_reg[j] (newest text byte in slot 0).
    logic [7:0]       pat_reg  [PATTERN_MAX];
    logic [7:0]       pat_next [PATTERN_MAX];
    logic [7:0]       win_reg  [PATTERN_MAX];
    logic [7:0]       win_next [PATTERN_MAX];

    logic [LEN_W-1:0] pat_len_reg, pat_len_next;
    logic             pat_done_reg, pat_done_next;
    logic             clip_reg, clip_next;
    logic [LEN_W-1:0] seen_reg, seen_next;
    logic             hit_reg, hit_next;
    logic             case_sens_reg, case_sens_next;

    // output register
    logic             m_valid_reg, m_valid_next;
    logic             found_reg, found_next;
    logic             oclip_reg, oclip_next;

    logic             s_fire;
    logic             text_end;
    logic             lanes_ok;
    logic             win_match;
    logic [LEN_W-1:0] seen_inc;
    logic [LEN_W-1:0] len_base;
    logic             clip_base;
    logic             cfg_write;

    assign s_ready  = !m_valid_reg || m_ready;
    assign s_fire   = s_valid && s_ready;
    assign text_end = s_fire && (s_op == OP_TEXT) && s_last;

    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_CASE_SENSITIVE)
                     ? {{(APB_DATA_W-1){1'b0}}, case_sens_reg} : '0;

    assign m_valid           = m_valid_reg;
    assign m_found           = found_reg;
    assign m_pattern_clipped = oclip_reg;

    always_comb begin
        // shifted window with the incoming byte in slot 0
        win_next[0] = s_ch;
        for (int i = 1; i < PATTERN_MAX; i++) begin
            win_next[i] = win_reg[i-1];
        end
        seen_inc = (seen_reg < LEN_MAX) ? seen_reg + LEN_W'(1) : seen_reg;

        // parallel lane compare, lanes at or beyond the pattern length ignored
        lanes_ok = 1'b1;
        for (int j = 0; j < PATTERN_MAX; j++) begin
            if ((LEN_W'(j) < pat_len_reg) &&
                (slf_fold(pat_reg[j], case_sens_reg) != slf_fold(win_next[j], case_sens_reg))) begin
                lanes_ok = 1'b0;
            end
        end
        win_match = lanes_ok && (pat_len_reg <= seen_inc);

        // pattern load: a new load restarts length and clip flag
        len_base  = pat_done_reg ? '0 : pat_len_reg;
        clip_base = pat_done_reg ? 1'b0 : clip_reg;
        pat_next[0] = s_ch;
        for (int i = 1; i < PATTERN_MAX; i++) begin
            pat_next[i] = pat_reg[i-1];
        end
    end

    always_comb begin
        pat_len_next   = pat_len_reg;
        pat_done_next  = pat_done_reg;
        clip_next      = clip_reg;
        seen_next      = seen_reg;
        hit_next       = hit_reg;
        case_sens_next = case_sens_reg;
        m_valid_next   = m_valid_reg;
        found_next     = found_reg;
        oclip_next     = oclip_reg;

        if (cfg_write && (paddr[2] == REG_CASE_SENSITIVE)) begin
            case_sens_next = pwdata[0];
        end

        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        if (s_fire) begin
            case (s_op)
                OP_PATTERN: begin
                    if (len_base < LEN_MAX) begin
                        pat_len_next = len_base + LEN_W'(1);
                        clip_next    = clip_base;
                    end else begin
                        pat_len_next = len_base;
                        clip_next    = 1'b1;
                    end
                    pat_done_next = s_last;
                end
                OP_TEXT: begin
                    if (s_last) begin
                        m_valid_next = 1'b1;
                        found_next   = hit_reg || win_match;
                        oclip_next   = clip_reg;
                        hit_next     = 1'b0;
                        seen_next    = '0;
                    end else begin
                        hit_next  = hit_reg || win_match;
                        seen_next = seen_inc;
                    end
                end
                default: begin
                    hit_next = hit_reg;
                end
            endcase
        end
    end

    // payload shift lines
    always_ff @(posedge aclk) begin
        if (s_fire && (s_op == OP_TEXT)) begin
            win_reg <= win_next;
        end
        if (s_fire && (s_op == OP_PATTERN) && (len_base < LEN_MAX)) begin
            pat_reg <= pat_next;
        end
        found_reg <= found_next;
        oclip_reg <= oclip_next;
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_len_reg   <= '0;
            pat_done_reg  <= 1'b1;
            clip_reg      <= 1'b0;
            seen_reg      <= '0;
            hit_reg       <= 1'b0;
            case_sens_reg <= 1'b1;
            m_valid_reg   <= 1'b0;
        end else begin
            pat_len_reg   <= pat_len_next;
            pat_done_reg  <= pat_done_next;
            clip_reg      <= clip_next;
            seen_reg      <= seen_next;
            hit_reg       <= hit_next;
            case_sens_reg <= case_sens_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // checks
    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (pat_len_reg <= LEN_MAX) && (seen_reg <= LEN_MAX))
        else $error("length counter beyond capacity");

    a_verdict_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        text_end |=> m_valid_reg)
        else $error("line end gave no verdict");

    a_line_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        text_end |=> (!hit_reg && (seen_reg == '0)))
        else $error("line state not cleared at line end");

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !s_ready)
        else $error("input taken while verdict stalled");

    a_clip_full: assert property (@(posedge aclk) disable iff (!aresetn)
        clip_reg |-> (pat_len_reg == LEN_MAX))
        else $error("clip flag set below capacity");

endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for substring_line_filter: directed and random pattern/text items,
// per-line verdicts predicted in the bench and checked field by field on the m_ channel.
// Depends on slf_pkg and the substring_line_filter RTL.
module tb;
    import slf_pkg::*;

    localparam int unsigned PAT_CAP      = PATTERN_MAX_DEF;
    localparam int unsigned STALL_LIMIT  = 2000;   // cycles with no handshake before giving up
    localparam int unsigned DRAIN_CYCLES = 8;      // the verdict is registered after its last byte
    localparam int unsigned MAX_REPORTS  = 10;
    localparam logic [7:0]  ASCII_LOWER_Z = 8'h7A;
    localparam logic [7:0]  CASE_BIT      = 8'h20;
    localparam string       ALPHABET      = "aAbBZz@[{";   // letters plus fold boundaries
    localparam logic [APB_ADDR_W-1:0] ADDR_CASE_SENSITIVE =
        APB_ADDR_W'(4 * int'(REG_CASE_SENSITIVE));

    typedef struct packed {
        logic       op;
        logic [7:0] ch;
        logic       last;
    } byte_item_t;

    typedef struct packed {
        logic found;
        logic clipped;
    } verdict_t;

    // receiver back-pressure styles, picked at random and re-rolled over the run
    typedef enum logic [1:0] {SINK_OPEN, SINK_COIN, SINK_THIRD, SINK_MOSTLY} sink_mode_t;

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_op    = OP_TEXT;
    logic [7:0]            s_ch    = 8'h00;
    logic                  s_last  = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic                  m_found;
    logic                  m_pattern_clipped;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    substring_line_filter #(
        .PATTERN_MAX(PAT_CAP)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_op(s_op),
        .s_ch(s_ch),
        .s_last(s_last),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_found(m_found),
        .m_pattern_clipped(m_pattern_clipped),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    // 2 ns period
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Search state mirrored in the bench
    // ------------------------------------------------------------------
    logic [7:0]  pat_mem [PAT_CAP];
    int unsigned pat_len    = 0;
    logic        pat_closed = 1'b1;   // next pattern item starts a fresh load
    logic        pat_over   = 1'b0;   // load ran past capacity
    logic [7:0]  line_win [PAT_CAP];  // slot 0 holds the newest text byte
    int unsigned line_seen  = 0;      // saturates at PAT_CAP
    logic        line_hit   = 1'b0;
    logic        case_sens  = 1'b1;   // follows the case_sensitive register

    verdict_t    verdict_q [$];       // verdicts owed by the block, oldest first
    byte_item_t  pend_q [$];          // items waiting for the driver
    logic [7:0]  gen_pat [$];         // stimulus-side copy of the current pattern

    int unsigned pushed = 0, accepted = 0, quiet = 0, errors = 0;
    int unsigned n_pat = 0, n_text = 0, n_verdicts = 0, n_found = 0, n_clipped = 0;
    int unsigned n_writes = 0;
    logic        took = 1'b0;         // input item taken at the last rising edge
    int unsigned burst_left = 1, gap_left = 0, cyc = 0;
    sink_mode_t  sink_mode = SINK_OPEN;

    function automatic logic [7:0] norm_byte(input logic [7:0] c);
        if (!case_sens && c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z) begin
            return c + (ASCII_LOWER_A - ASCII_UPPER_A);
        end
        return c;
    endfunction

    // does the loaded pattern end on the newest byte of the line?
    function automatic logic pattern_ends_here();
        if (pat_len > line_seen) begin
            return 1'b0;
        end
        for (int k = 0; k < pat_len; k++) begin
            if (norm_byte(pat_mem[k]) != norm_byte(line_win[pat_len - 1 - k])) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic void track_byte(input byte_item_t it);
        verdict_t v;
        if (it.op == OP_PATTERN) begin
            if (pat_closed) begin
                pat_len    = 0;
                pat_over   = 1'b0;
                pat_closed = 1'b0;
            end
            if (pat_len < PAT_CAP) begin
                pat_mem[pat_len] = it.ch;
                pat_len++;
            end else begin
                pat_over = 1'b1;
            end
            if (it.last) begin
                pat_closed = 1'b1;
            end
        end else begin
            for (int k = PAT_CAP - 1; k > 0; k--) begin
                line_win[k] = line_win[k - 1];
            end
            line_win[0] = it.ch;
            if (line_seen < PAT_CAP) begin
                line_seen++;
            end
            if (pattern_ends_here()) begin
                line_hit = 1'b1;
            end
            if (it.last) begin
                v.found   = line_hit;
                v.clipped = pat_over;
                verdict_q = {verdict_q, v};
                line_hit  = 1'b0;
                line_seen = 0;
                foreach (line_win[k]) begin
                    line_win[k] = 8'h00;
                end
            end
        end
    endfunction

    function automatic void flag_mismatch(input string what, input logic [1:0] want,
                                          input logic [1:0] got);
        errors++;
        if (errors <= MAX_REPORTS) begin
            $display("%0t: mismatch on %s: expected %b, got %b", $time, what, want, got);
        end
    endfunction

    // ------------------------------------------------------------------
    // Rising edge: take input items into the prediction, check verdicts
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : watch_ports
        byte_item_t it;
        verdict_t   want;
        took = aresetn && s_valid && s_ready;
        if (took) begin
            it.op   = s_op;
            it.ch   = s_ch;
            it.last = s_last;
            track_byte(it);
            accepted++;
            if (s_op == OP_PATTERN) begin
                n_pat++;
            end else begin
                n_text++;
            end
        end
        if (aresetn && m_valid && m_ready) begin
            if (verdict_q.size() == 0) begin
                flag_mismatch("verdict with none pending", 2'bxx,
                              {m_found, m_pattern_clipped});
            end else begin
                want = verdict_q.pop_front();
                n_verdicts++;
                if (want.found) begin
                    n_found++;
                end
                if (want.clipped) begin
                    n_clipped++;
                end
                if (m_found !== want.found) begin
                    flag_mismatch("found", {1'b0, want.found}, {1'b0, m_found});
                end
                if (m_pattern_clipped !== want.clipped) begin
                    flag_mismatch("pattern_clipped", {1'b0, want.clipped},
                                  {1'b0, m_pattern_clipped});
                end
            end
        end
        if (took || (m_valid && m_ready)) begin
            quiet = 0;
        end else begin
            quiet++;
        end
    end

    // ------------------------------------------------------------------
    // Falling edge: sender in bursts with gaps; valid holds until taken
    // ------------------------------------------------------------------
    always @(negedge aclk) begin : drive_items
        byte_item_t nxt;
        logic       nxt_valid;
        nxt.op    = s_op;
        nxt.ch    = s_ch;
        nxt.last  = s_last;
        nxt_valid = s_valid;
        if (!s_valid || took) begin
            nxt_valid = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (pend_q.size() > 0) begin
                nxt       = pend_q.pop_front();
                nxt_valid = 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else if ($urandom_range(0, 9) == 0) begin
                    // long stretch without any idling
                    burst_left = 40;
                    gap_left   = 0;
                end else begin
                    burst_left = $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 20)
                                                              : $urandom_range(0, 3);
                end
            end
        end
        s_valid <= nxt_valid;
        s_op    <= nxt.op;
        s_ch    <= nxt.ch;
        s_last  <= nxt.last;
    end

    // receiver stalls on a pattern of its own, independent of the sender
    always @(negedge aclk) begin : drive_ready
        logic rdy;
        if (cyc % 64 == 0) begin
            sink_mode = sink_mode_t'($urandom_range(0, 3));
        end
        case (sink_mode)
            SINK_OPEN:  rdy = 1'b1;
            SINK_COIN:  rdy = 1'($urandom_range(0, 1));
            SINK_THIRD: rdy = (cyc % 3 == 0);
            default:    rdy = ($urandom_range(0, 3) != 0);
        endcase
        cyc++;
        m_ready <= rdy;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic put(input logic op, input logic [7:0] ch, input logic last);
        byte_item_t it;
        it.op   = op;
        it.ch   = ch;
        it.last = last;
        pend_q = {pend_q, it};
        pushed++;
    endtask

    task automatic put_str(input logic op, input string s);
        for (int i = 0; i < s.len(); i++) begin
            put(op, s[i], i == s.len() - 1);
        end
    endtask

    function automatic logic [7:0] pick_byte();
        if ($urandom_range(0, 9) < 7) begin
            return ALPHABET[$urandom_range(0, ALPHABET.len() - 1)];
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] swap_case(input logic [7:0] c);
        if (((c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z) ||
             (c >= ASCII_LOWER_A && c <= ASCII_LOWER_Z)) && $urandom_range(0, 1)) begin
            return c ^ CASE_BIT;
        end
        return c;
    endfunction

    // block idle: every item taken, every verdict in, then the pipeline drained
    task automatic wait_quiet();
        while (accepted != pushed || verdict_q.size() != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // write case_sensitive, then read it back; called at a falling edge while idle
    task automatic set_case_mode(input logic mode);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_CASE_SENSITIVE;
        pwdata  <= APB_DATA_W'(mode);
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case_sens = mode;
        n_writes++;
        @(negedge aclk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== APB_DATA_W'(mode)) begin
            flag_mismatch("case_sensitive read-back", {1'b0, mode}, prdata[1:0]);
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Mostly well-formed: pattern loads and lines that often carry the pattern
    // (case randomly flipped); the rest is raw noise with random op and last.
    task automatic rand_phase(input int unsigned min_items, input int unsigned min_lines);
        int unsigned start, lines, len, pos, roll;
        logic [7:0]  b;
        logic        nop, nlast;
        logic [7:0]  line_buf [$];
        start = pushed;
        lines = 0;
        while (pushed - start < min_items || lines < min_lines) begin
            roll = $urandom_range(0, 99);
            if (roll < 15) begin
                roll = $urandom_range(0, 19);
                len  = (roll == 0) ? $urandom_range(PAT_CAP + 1, PAT_CAP + 6) :
                       (roll == 1) ? $urandom_range(6, PAT_CAP) : $urandom_range(1, 4);
                gen_pat.delete();
                for (int i = 0; i < len; i++) begin
                    b = pick_byte();
                    if (i < PAT_CAP) begin
                        gen_pat = {gen_pat, b};
                    end
                    put(OP_PATTERN, b, i == len - 1);
                end
            end else if (roll < 88) begin
                // occasional long line to saturate the character count
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 90)
                                                  : $urandom_range(1, 24);
                line_buf.delete();
                for (int i = 0; i < len; i++) begin
                    line_buf = {line_buf, pick_byte()};
                end
                if (gen_pat.size() <= len && $urandom_range(0, 9) < 6) begin
                    pos = $urandom_range(0, len - gen_pat.size());
                    foreach (gen_pat[i]) begin
                        line_buf[pos + i] = swap_case(gen_pat[i]);
                    end
                end
                foreach (line_buf[i]) begin
                    put(OP_TEXT, line_buf[i], i == len - 1);
                end
                lines++;
            end else begin
                for (int i = $urandom_range(1, 6); i > 0; i--) begin
                    nop   = 1'($urandom_range(0, 1));
                    nlast = 1'($urandom_range(0, 1));
                    put(nop, 8'($urandom_range(0, 255)), nlast);
                    if (nop == OP_TEXT && nlast) begin
                        lines++;
                    end
                end
            end
        end
    endtask

    initial begin : watchdog
        while (quiet < STALL_LIMIT) begin
            @(negedge aclk);
        end
        $display("No handshake for %0d cycles, giving up", STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : run
        logic [7:0] ovf [PAT_CAP];
        logic       phase_mode [5];
        foreach (line_win[k]) begin
            line_win[k] = 8'h00;
        end
        phase_mode = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0};
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed, exact matching (reset value)
        put_str(OP_TEXT, "x");                 // nothing loaded yet: every line hits
        put(OP_TEXT, 8'h00, 1'b0);
        put(OP_TEXT, 8'hFF, 1'b1);
        put_str(OP_PATTERN, "Ab");
        put_str(OP_TEXT, "zAb");               // hit on the final bytes
        put_str(OP_TEXT, "A");                 // line shorter than the pattern
        put_str(OP_TEXT, "aB");                // differs only in case
        put(OP_TEXT, "q", 1'b0);               // line left open...
        put_str(OP_PATTERN, "f");              // ...pattern replaced mid-line
        put_str(OP_TEXT, "f");
        put(OP_PATTERN, "c", 1'b0);            // load left open
        put_str(OP_TEXT, "c");                 // compared with the partial pattern
        put_str(OP_PATTERN, "d");              // load continues to "cd"
        put_str(OP_TEXT, "xcd");
        put(OP_PATTERN, 8'hFF, 1'b1);
        put(OP_TEXT, 8'h00, 1'b0);
        put(OP_TEXT, 8'hFF, 1'b1);
        wait_quiet();

        // Directed, folded matching: letters fold, '[' and '{' must not
        set_case_mode(1'b0);
        put_str(OP_PATTERN, "aB[");
        put_str(OP_TEXT, "xAb{");
        put_str(OP_TEXT, "zAB[");

        // Overflow: a load two bytes past capacity, then a fresh load clears the flag
        foreach (ovf[i]) begin
            ovf[i] = $urandom_range(0, 1) ? "a" : "b";
            put(OP_PATTERN, ovf[i], 1'b0);
        end
        put(OP_PATTERN, "z", 1'b0);
        put(OP_PATTERN, "z", 1'b1);
        foreach (ovf[i]) begin
            put(OP_TEXT, swap_case(ovf[i]), i == PAT_CAP - 1);
        end
        put_str(OP_PATTERN, "q");
        put_str(OP_TEXT, "Q");
        wait_quiet();

        // Random phases; the sender idles between them until all verdicts are in
        foreach (phase_mode[p]) begin
            set_case_mode(phase_mode[p]);
            rand_phase(60, 4);
            wait_quiet();
        end

        $display("Covered %0d items (%0d pattern, %0d text) and %0d line verdicts,",
                 n_pat + n_text, n_pat, n_text, n_verdicts);
        $display("%0d with a hit, %0d with a clipped pattern, %0d mode writes, %0d errors.",
                 n_found, n_clipped, n_writes, errors);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
